[design/mbrtu_pkg.sv]
// Shared types, codes and helper functions for the Modbus RTU frame receiver.
package mbrtu_pkg;

  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [15:0] TIMEOUT_DEFAULT = 16'd1000;
  localparam logic [15:0] QUIET_MAX       = 16'hFFFF;

  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

  localparam logic [8:0] LEN_EXCEPTION = 9'd5;
  localparam logic [8:0] LEN_FIXED     = 9'd8;
  localparam logic [8:0] LEN_READ_BASE = 9'd5;
  localparam logic [8:0] LEN_MULTI_BASE = 9'd9;
  localparam logic [8:0] POS_CLIENT_CNT = 9'd3;
  localparam logic [8:0] POS_SERVER_CNT = 9'd7;

  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_TICK = 2'd1,
    REQ_SENT = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RECV = 2'd1,
    PH_WAIT = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_OK      = 3'd1,
    EV_CRC     = 3'd2,
    EV_UNSUP   = 3'd3,
    EV_OVF     = 3'd4,
    EV_TIMEOUT = 3'd5,
    EV_ACCEPT  = 3'd6
  } event_e;

  typedef enum logic {
    REG_ROLE    = 1'b0,
    REG_TIMEOUT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } mb_in_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic [7:0] data_byte;
    logic [7:0] byte_position;
    logic [7:0] unit_address;
    logic [7:0] function_code;
    logic [8:0] expected_len;
    logic [1:0] link_state;
  } mb_out_t;

  typedef struct packed {
    logic        role_is_server;
    logic [15:0] response_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       unsup;
    logic [8:0] len;
  } len_t;

  // Modbus CRC-16, reflected, one byte folded in.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Expected frame length from the header; n is the byte count after this byte.
  function automatic len_t frame_len(logic [8:0] n, logic [7:0] cur, logic [7:0] fn,
                                     logic server);
    len_t       r;
    logic [7:0] base;
    r    = '{unsup: 1'b0, len: '0};
    base = {1'b0, fn[6:0]};
    if (n < 9'd2) begin
      r.len = '0;
    end else if (fn[7]) begin
      r.len = (n >= 9'd3) ? LEN_EXCEPTION : '0;
    end else if (server) begin
      case (base) inside
        FC_READ_HOLDING, FC_WRITE_SINGLE: r.len = LEN_FIXED;
        FC_WRITE_MULTI: r.len = (n == POS_SERVER_CNT) ? (LEN_MULTI_BASE + 9'(cur)) : '0;
        default: r.unsup = 1'b1;
      endcase
    end else begin
      case (base) inside
        FC_READ_HOLDING: r.len = (n == POS_CLIENT_CNT) ? (LEN_READ_BASE + 9'(cur)) : '0;
        FC_WRITE_SINGLE, FC_WRITE_MULTI: r.len = LEN_FIXED;
        default: r.unsup = 1'b1;
      endcase
    end
    return r;
  endfunction

endpackage

[design/modbus_rtu_frame_receiver_top.sv]
// Modbus RTU frame receiver: input register, frame engine, result register.
//
//   channel | direction | handshake                | beat
//   in      | input     | in_valid_i / in_ready_o  | mb_in_t  (req_type, rx_byte)
//   out     | output    | out_valid_o / out_ready_i| mb_out_t (event and frame status)
//   cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// One beat per cycle while the output is not stalled; each input beat yields one
// output beat, through the input register and then the result register.
// The frame state updates in the cycle a beat moves from the input register into the
// result register, so the CRC and length logic sit in that single stage.
// A stalled output holds the result register; the input register still takes one
// more beat. Reset clears all frame state, config and both valid flags at once.
module modbus_rtu_frame_receiver_top #(
  parameter int BUF_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mbrtu_pkg::mb_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mbrtu_pkg::mb_out_t out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);
  import mbrtu_pkg::*;

  logic    in_vld_q;
  mb_in_t  in_q;
  logic    out_vld_q;
  mb_out_t out_q;
  logic    advance;
  cfg_t    cfg;
  mb_out_t res;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  mbrtu_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mbrtu_engine #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (in_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

[design/mbrtu_cfg_regs.sv]
// Configuration registers: role select and client response timeout.
module mbrtu_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  output mbrtu_pkg::cfg_t     cfg_o
);
  import mbrtu_pkg::*;

  logic        role_q;
  logic [15:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q    <= 1'b0;
      timeout_q <= TIMEOUT_DEFAULT;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ROLE:    role_q    <= cfg_wdata_i[0];
        REG_TIMEOUT: timeout_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = '{role_is_server: role_q, response_timeout_ticks: timeout_q};

endmodule

[design/mbrtu_engine.sv]
// Frame state, running CRC, length decode and event logic for one beat.
module mbrtu_engine #(
  parameter int BUF_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_en_i,
  input  mbrtu_pkg::mb_in_t  item_i,
  input  mbrtu_pkg::cfg_t    cfg_i,
  output mbrtu_pkg::mb_out_t res_o
);
  import mbrtu_pkg::*;

  logic [8:0]  count_q, count_d;
  logic [8:0]  expect_q, expect_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  addr_q, addr_d;
  logic [7:0]  func_q, func_d;
  phase_e      phase_q, phase_d;
  logic [15:0] quiet_q, quiet_d;

  event_e      ev;
  logic [7:0]  data;
  logic [7:0]  pos;
  logic [8:0]  flen;
  logic [8:0]  n;
  logic [8:0]  exp_cur;
  logic [15:0] crc_new;
  logic [15:0] quiet_inc;
  logic [15:0] limit;
  logic        buf_full;
  logic        sent_ok;
  len_t        len;

  assign buf_full  = 32'(count_q) >= BUF_DEPTH;
  assign n         = count_q + 9'd1;
  assign crc_new   = crc_byte(crc_q, item_i.rx_byte);
  assign quiet_inc = (quiet_q != QUIET_MAX) ? (quiet_q + 16'd1) : quiet_q;
  assign limit     = (cfg_i.response_timeout_ticks != '0) ? cfg_i.response_timeout_ticks
                                                          : TIMEOUT_DEFAULT;
  assign sent_ok   = cfg_i.role_is_server ? (phase_q == PH_IDLE || phase_q == PH_RECV)
                                          : (phase_q == PH_IDLE);

  always_comb begin
    count_d  = count_q;
    expect_d = expect_q;
    crc_d    = crc_q;
    addr_d   = addr_q;
    func_d   = func_q;
    phase_d  = phase_q;
    quiet_d  = quiet_q;
    ev       = EV_NONE;
    data     = '0;
    pos      = '0;
    flen     = expect_q;
    exp_cur  = expect_q;
    len      = '0;
    unique case (req_e'(item_i.req_type))
      REQ_BYTE: begin
        data = item_i.rx_byte;
        pos  = count_q[7:0];
        if (buf_full) begin
          // drop the byte and empty the buffer
          count_d  = '0;
          expect_d = '0;
          crc_d    = CRC_INIT;
          ev       = EV_OVF;
          flen     = '0;
        end else begin
          if (count_q == 9'd0) begin
            addr_d = item_i.rx_byte;
          end else if (count_q == 9'd1) begin
            func_d = item_i.rx_byte;
          end
          crc_d   = crc_new;
          count_d = n;
          quiet_d = '0;
          if (!cfg_i.role_is_server) begin
            phase_d = PH_WAIT;
          end else if (phase_q == PH_IDLE) begin
            phase_d = PH_RECV;
          end
          if (expect_q == '0) begin
            len = frame_len(n, item_i.rx_byte, func_d, cfg_i.role_is_server);
            if (len.unsup) begin
              count_d = '0;
              crc_d   = CRC_INIT;
              exp_cur = '0;
              ev      = EV_UNSUP;
            end else begin
              exp_cur = len.len;
            end
            expect_d = exp_cur;
          end
          flen = exp_cur;
          if (ev == EV_NONE && exp_cur != '0 && n >= exp_cur) begin
            ev       = (crc_new == '0) ? EV_OK : EV_CRC;
            count_d  = '0;
            crc_d    = CRC_INIT;
            expect_d = '0;
            phase_d  = PH_IDLE;
            quiet_d  = '0;
          end
        end
      end
      REQ_TICK: begin
        quiet_d = quiet_inc;
        if (!cfg_i.role_is_server && phase_q == PH_WAIT && quiet_inc >= limit) begin
          ev      = EV_TIMEOUT;
          phase_d = PH_IDLE;
          quiet_d = '0;
        end
      end
      REQ_SENT: begin
        if (sent_ok) begin
          phase_d  = cfg_i.role_is_server ? PH_IDLE : PH_WAIT;
          count_d  = '0;
          expect_d = '0;
          crc_d    = CRC_INIT;
          quiet_d  = '0;
          ev       = EV_ACCEPT;
          flen     = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      expect_q <= '0;
      crc_q    <= CRC_INIT;
      addr_q   <= '0;
      func_q   <= '0;
      phase_q  <= PH_IDLE;
      quiet_q  <= '0;
    end else if (step_en_i) begin
      count_q  <= count_d;
      expect_q <= expect_d;
      crc_q    <= crc_d;
      addr_q   <= addr_d;
      func_q   <= func_d;
      phase_q  <= phase_d;
      quiet_q  <= quiet_d;
    end
  end

  assign res_o = '{event_code:    ev,
                   data_byte:     data,
                   byte_position: pos,
                   unit_address:  addr_d,
                   function_code: func_d,
                   expected_len:  flen,
                   link_state:    phase_d};

endmodule

[design/mbrtu_checker.sv]
// Port-level checks on the result channel of the frame receiver, with bind.
module mbrtu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input mbrtu_pkg::mb_out_t out_data_i
);
  import mbrtu_pkg::*;

  logic out_beat;
  assign out_beat = out_valid_i && out_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result beat changed while stalled");

  a_frame_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && (out_data_i.event_code == EV_OK || out_data_i.event_code == EV_CRC)
    |-> out_data_i.expected_len != '0 && out_data_i.link_state == PH_IDLE)
    else $error("completed frame without length or not idle");

  a_cleared_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && (out_data_i.event_code == EV_UNSUP || out_data_i.event_code == EV_OVF ||
                 out_data_i.event_code == EV_ACCEPT)
    |-> out_data_i.expected_len == '0)
    else $error("frame length kept after buffer was emptied");

  a_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && out_data_i.event_code == EV_TIMEOUT
    |-> out_data_i.link_state == PH_IDLE && out_data_i.data_byte == '0
        && out_data_i.byte_position == '0)
    else $error("timeout beat with byte data or wrong link state");

endmodule

bind modbus_rtu_frame_receiver_top mbrtu_checker u_mbrtu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
